### design/assert_macros.svh
// Assertion macros shared by the RTL files. They expand to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk_i, rst_ni, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk_i, rst_ni, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");
`define ASSERT_NEVER(label, clk_i, rst_ni, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("assertion failed: forbidden condition");
`else
`define ASSERT_IMPLY(label, clk_i, rst_ni, pre, post)
`define ASSERT_NEXT(label, clk_i, rst_ni, pre, post)
`define ASSERT_NEVER(label, clk_i, rst_ni, expr)
`endif
`endif

### design/ebtn_pkg.sv
package ebtn_pkg;

  localparam int TIME_W      = 32;
  localparam int TAB_W       = 4;
  localparam int TAB_CNT_W   = 5;
  localparam int TAB_MAX     = 16;
  localparam int PRESS_W     = 16;
  localparam int ACC_W       = 8;
  localparam int ACC_LIMIT   = 127;
  localparam int EV_W        = 3;
  localparam int IN_BITS     = 6;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int REM_W       = 6;
  localparam int MOD_STEPS   = 6;
  localparam int MOD_IDX_W   = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_TAB_COUNT     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PRESS     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SLEEP_TIMEOUT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BUTTON_EXT    = 3'd4;

  // Event codes reported with each result.
  localparam logic [EV_W-1:0] EV_NONE  = 3'd0;
  localparam logic [EV_W-1:0] EV_MOVE  = 3'd1;
  localparam logic [EV_W-1:0] EV_SHORT = 3'd2;
  localparam logic [EV_W-1:0] EV_LONG  = 3'd3;
  localparam logic [EV_W-1:0] EV_WOKE  = 3'd4;
  localparam logic [EV_W-1:0] EV_SLEPT = 3'd5;

  typedef struct packed {
    logic nav_inhibit;
    logic wake_request;
    logic poll;
    logic button_down;
    logic enc_b;
    logic enc_a;
  } in_item_t;

  typedef struct packed {
    logic [EV_W-1:0]  event_code;
    logic             sleeping;
    logic [TAB_W-1:0] current_tab;
  } out_item_t;

  typedef struct packed {
    logic                 load;
    logic                 decode;
    logic                 rule;
    logic                 mod_step;
    logic                 tab_commit;
    logic                 out_load;
    logic [MOD_IDX_W-1:0] mod_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic move;
  } dp_stat_t;

  // Quadrature step for {previous A, previous B, current A, current B}.
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] step;
    step = 2'sd0;
    if (idx inside {4'd2, 4'd4, 4'd11, 4'd13}) begin
      step = 2'sd1;
    end else if (idx inside {4'd1, 4'd7, 4'd8, 4'd14}) begin
      step = -2'sd1;
    end
    return step;
  endfunction

endpackage

### design/ebtn_ctrl.sv
`include "assert_macros.svh"

module ebtn_ctrl
  import ebtn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     out_tready,
  output logic     out_tvalid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RULE = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_TAB  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [MOD_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 out_free;

  assign out_free   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    cmd.mod_idx    = MOD_IDX_W'(MOD_STEPS - 1) - cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        state_nxt  = S_RULE;
      end
      S_RULE: begin
        cmd.rule = 1'b1;
        cnt_nxt  = '0;
        state_nxt = stat.move ? S_MOD : S_OUT;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (cnt_r == MOD_IDX_W'(MOD_STEPS - 1)) begin
          state_nxt = S_TAB;
        end else begin
          cnt_nxt = cnt_r + MOD_IDX_W'(1);
        end
      end
      S_TAB: begin
        cmd.tab_commit = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        // The finished result waits here until the output register is free.
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  `ASSERT_NEXT(a_accept_starts_decode, clk, rst_n, in_tvalid && in_tready, state_r == S_DEC)
  `ASSERT_IMPLY(a_no_result_overwrite, clk, rst_n, cmd.out_load, !out_tvalid_r || out_tready)
  `ASSERT_IMPLY(a_mod_count_bound, clk, rst_n, state_r == S_MOD, cnt_r < MOD_IDX_W'(MOD_STEPS))

endmodule

### design/ebtn_dp.sv
`include "assert_macros.svh"

module ebtn_dp
  import ebtn_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Configuration registers.
  logic [TAB_CNT_W-1:0] tab_count_r;
  logic [PRESS_W-1:0]   min_press_r;
  logic [PRESS_W-1:0]   long_press_r;
  logic [TIME_W-1:0]    sleep_to_r;
  logic                 btn_ext_r;

  // Tick state.
  in_item_t                item_r;
  logic [1:0]              enc_prev_r;
  logic signed [ACC_W-1:0] accum_r;
  logic [TIME_W-1:0]       tick_r;
  logic [TIME_W-1:0]       press_start_r;
  logic [TIME_W-1:0]       last_act_r;
  logic                    bwd_r;
  logic                    asleep_r;
  logic                    wake_pend_r;
  logic [TAB_W-1:0]        tab_r;
  logic                    hold_min_r;
  logic                    hold_long_r;
  logic                    idle_gt_r;
  logic [EV_W-1:0]         ev_r;
  logic [REM_W-1:0]        rem_r;
  logic                    neg_r;
  out_item_t               out_r;

  // Decode path.
  logic [3:0]              quad_idx;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic [TIME_W-1:0]       hold;
  logic [TIME_W-1:0]       idle;

  // Update rule.
  logic                 asleep_nxt;
  logic                 wake_nxt;
  logic                 bwd_nxt;
  logic [TIME_W-1:0]    press_start_nxt;
  logic [TIME_W-1:0]    last_act_nxt;
  logic                 accum_clr;
  logic [EV_W-1:0]      ev_nxt;
  logic                 move;
  logic                 move_enc;
  logic                 woke;
  logic                 done;

  // Tab arithmetic.
  logic [TAB_CNT_W-1:0]       tab_n;
  logic [ACC_W-2:0]           acc_mag;
  logic [TAB_CNT_W-1:0]       step_mag;
  logic                       step_neg;
  logic signed [REM_W:0]      tab_sum;
  logic [REM_W-1:0]           sum_abs;
  logic [REM_W+TAB_CNT_W-1:0] div_sh;
  logic [TAB_CNT_W-1:0]       wrap_val;

  assign quad_idx = {enc_prev_r, item_r.enc_a, item_r.enc_b};
  assign acc_sum  = (ACC_W + 1)'(accum_r) + (ACC_W + 1)'(quad_step(quad_idx));

  always_comb begin
    if (acc_sum > (ACC_W + 1)'(ACC_LIMIT)) begin
      acc_sat = ACC_W'(ACC_LIMIT);
    end else if (acc_sum < -(ACC_W + 1)'(ACC_LIMIT)) begin
      acc_sat = -ACC_W'(ACC_LIMIT);
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  assign hold = tick_r - press_start_r;
  assign idle = tick_r - last_act_r;

  always_comb begin
    if (tab_count_r == '0) begin
      tab_n = TAB_CNT_W'(1);
    end else if (tab_count_r > TAB_CNT_W'(TAB_MAX)) begin
      tab_n = TAB_CNT_W'(TAB_MAX);
    end else begin
      tab_n = tab_count_r;
    end
  end

  // The last action of a poll decides the event code.
  always_comb begin
    asleep_nxt      = asleep_r;
    wake_nxt        = wake_pend_r;
    bwd_nxt         = bwd_r;
    press_start_nxt = press_start_r;
    last_act_nxt    = last_act_r;
    accum_clr       = 1'b0;
    ev_nxt          = EV_NONE;
    move            = 1'b0;
    move_enc        = 1'b0;
    woke            = 1'b0;
    done            = 1'b0;
    if (item_r.poll) begin
      woke = wake_pend_r && asleep_r;
      if (woke) begin
        wake_nxt     = 1'b0;
        asleep_nxt   = 1'b0;
        last_act_nxt = tick_r;
        ev_nxt       = EV_WOKE;
      end
      if (asleep_r && !woke) begin
        if (!btn_ext_r) begin
          if (item_r.button_down) begin
            if (!bwd_r) begin
              bwd_nxt         = 1'b1;
              press_start_nxt = tick_r;
            end
          end else if (bwd_r && hold_min_r) begin
            bwd_nxt      = 1'b0;
            asleep_nxt   = 1'b0;
            last_act_nxt = tick_r;
            ev_nxt       = EV_WOKE;
          end else begin
            bwd_nxt = 1'b0;
          end
        end
      end else begin
        if (!item_r.nav_inhibit && !btn_ext_r) begin
          accum_clr = 1'b1;
          if (accum_r != '0) begin
            move         = 1'b1;
            move_enc     = 1'b1;
            last_act_nxt = tick_r;
            ev_nxt       = EV_MOVE;
            done         = 1'b1;
          end
        end
        if (!done && !btn_ext_r) begin
          if (item_r.button_down) begin
            if (!bwd_r) begin
              bwd_nxt         = 1'b1;
              press_start_nxt = tick_r;
            end
          end else if (bwd_r) begin
            last_act_nxt = tick_r;
            bwd_nxt      = 1'b0;
            done         = 1'b1;
            if (hold_min_r && !hold_long_r) begin
              move   = 1'b1;
              ev_nxt = EV_SHORT;
            end else if (hold_long_r) begin
              ev_nxt = EV_LONG;
            end
          end
        end
        // A wake on this poll has just refreshed the activity time.
        if (!done && idle_gt_r && !woke) begin
          asleep_nxt = 1'b1;
          ev_nxt     = EV_SLEPT;
        end
      end
    end
  end

  // Encoder steps are the accumulator divided by four, at least one.
  assign acc_mag  = accum_r[ACC_W-1] ? (ACC_W - 1)'(-accum_r) : accum_r[ACC_W-2:0];
  assign step_neg = move_enc && accum_r[ACC_W-1];

  always_comb begin
    if (!move_enc || (acc_mag[ACC_W-2:2] == '0)) begin
      step_mag = TAB_CNT_W'(1);
    end else begin
      step_mag = acc_mag[ACC_W-2:2];
    end
  end

  always_comb begin
    if (step_neg) begin
      tab_sum = (REM_W + 1)'(tab_r) - (REM_W + 1)'(step_mag);
    end else begin
      tab_sum = (REM_W + 1)'(tab_r) + (REM_W + 1)'(step_mag);
    end
  end

  assign sum_abs  = tab_sum[REM_W] ? REM_W'(-tab_sum) : tab_sum[REM_W-1:0];
  assign div_sh   = (REM_W + TAB_CNT_W)'(tab_n) << cmd.mod_idx;
  assign wrap_val = tab_n - rem_r[TAB_CNT_W-1:0];

  assign stat.move = move;
  assign out_tdata = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_count_r   <= TAB_CNT_W'(6);
      min_press_r   <= PRESS_W'(30);
      long_press_r  <= PRESS_W'(500);
      sleep_to_r    <= TIME_W'(30000);
      btn_ext_r     <= 1'b0;
      enc_prev_r    <= 2'b11;
      accum_r       <= '0;
      tick_r        <= '0;
      press_start_r <= '0;
      last_act_r    <= '0;
      bwd_r         <= 1'b0;
      asleep_r      <= 1'b0;
      wake_pend_r   <= 1'b0;
      tab_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TAB_COUNT:     tab_count_r  <= cfg_wdata[TAB_CNT_W-1:0];
          REG_MIN_PRESS:     min_press_r  <= cfg_wdata[PRESS_W-1:0];
          REG_LONG_PRESS:    long_press_r <= cfg_wdata[PRESS_W-1:0];
          REG_SLEEP_TIMEOUT: sleep_to_r   <= cfg_wdata[TIME_W-1:0];
          REG_BUTTON_EXT:    btn_ext_r    <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (cmd.decode) begin
        enc_prev_r <= {item_r.enc_a, item_r.enc_b};
        accum_r    <= acc_sat;
        if (item_r.wake_request) begin
          wake_pend_r <= 1'b1;
        end
      end
      if (cmd.rule) begin
        asleep_r      <= asleep_nxt;
        wake_pend_r   <= wake_nxt;
        bwd_r         <= bwd_nxt;
        press_start_r <= press_start_nxt;
        last_act_r    <= last_act_nxt;
        if (accum_clr) begin
          accum_r <= '0;
        end
      end
      if (cmd.tab_commit) begin
        if (neg_r && (rem_r != '0)) begin
          tab_r <= wrap_val[TAB_W-1:0];
        end else begin
          tab_r <= rem_r[TAB_W-1:0];
        end
      end
      if (cmd.out_load) begin
        tick_r <= tick_r + TIME_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item_t'(in_tdata[IN_BITS-1:0]);
    end
    if (cmd.decode) begin
      hold_min_r  <= (hold >= TIME_W'(min_press_r));
      hold_long_r <= (hold >= TIME_W'(long_press_r));
      idle_gt_r   <= (idle > sleep_to_r);
    end
    if (cmd.rule) begin
      ev_r  <= ev_nxt;
      rem_r <= sum_abs;
      neg_r <= tab_sum[REM_W];
    end
    // Restoring remainder: one shifted tab count tried per cycle.
    if (cmd.mod_step) begin
      if ((REM_W + TAB_CNT_W)'(rem_r) >= div_sh) begin
        rem_r <= rem_r - div_sh[REM_W-1:0];
      end
    end
    if (cmd.out_load) begin
      out_r.current_tab <= tab_r;
      out_r.sleeping    <= asleep_r;
      out_r.event_code  <= ev_r;
    end
  end

  `ASSERT_NEVER(a_acc_saturated, clk, rst_n, accum_r == 8'sh80)
  `ASSERT_IMPLY(a_rem_below_count, clk, rst_n, cmd.tab_commit, rem_r < REM_W'(tab_n))
  `ASSERT_NEXT(a_out_follows_state, clk, rst_n, cmd.out_load, out_r.sleeping == asleep_r && out_r.current_tab == tab_r)

endmodule

### design/encoder_button_tab_navigator_top.sv
// Channel   Direction  Payload
// in_       slave      one tick: encoder levels, button level, poll and wake flags
// out_      master     one result per tick: tab index, sleep flag, event code
// cfg_      write      tab count, press thresholds, sleep timeout, button handling
//
// A tick passes through the accepting, decode, rule and output states, and when the tab moves
// also through the states that find the remainder by the tab count in a 6-step
// shift-and-subtract unit and commit the new tab.
// One tick is processed at a time; a new tick is accepted as soon as the previous
// result sits in the output register, even if that result has not been taken.
// A stalled output holds the finished tick in the controller until the register frees.
// rst_n is synchronous and active low; state and config reset, payload registers do not.
module encoder_button_tab_navigator_top
  import ebtn_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // enc_a, enc_b, button_down, poll, wake_request, nav_inhibit, 2 zero bits
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // current_tab[3:0], sleeping, event_code[2:0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ebtn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  ebtn_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

### tb/encoder_button_tab_navigator_top_tb.sv
module encoder_button_tab_navigator_top_tb;
  import ebtn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DETENT = 4;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  encoder_button_tab_navigator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Configuration as the navigator sees it.
  logic [TAB_CNT_W-1:0] cf_tabs;
  logic [PRESS_W-1:0]   cf_min;
  logic [PRESS_W-1:0]   cf_long;
  logic [TIME_W-1:0]    cf_sleep;
  logic                 cf_ext;

  // Navigator state.
  logic [1:0]        nav_enc_prev;
  int                nav_acc;
  logic [TIME_W-1:0] nav_now;
  logic [TIME_W-1:0] nav_press_t;
  logic              nav_btn_held;
  logic              nav_asleep;
  logic              nav_wake_pend;
  logic [TAB_W-1:0]  nav_tab;
  logic [TIME_W-1:0] nav_last_act;

  in_item_t  tick_q[$];
  out_item_t exp_res[$];
  out_item_t mon_want;
  out_item_t mon_got;
  int        mismatches = 0;
  int        queued_n = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  bit        idle_on = 1'b1;
  logic [1:0] enc_lvl = 2'b11;

  function automatic void nav_reset();
    cf_tabs       = 5'd6;
    cf_min        = 16'd30;
    cf_long       = 16'd500;
    cf_sleep      = 32'd30000;
    cf_ext        = 1'b0;
    nav_enc_prev  = 2'b11;
    nav_acc       = 0;
    nav_now       = '0;
    nav_press_t   = '0;
    nav_btn_held  = 1'b0;
    nav_asleep    = 1'b0;
    nav_wake_pend = 1'b0;
    nav_tab       = '0;
    nav_last_act  = '0;
  endfunction

  function automatic int enc_delta(logic [3:0] idx);
    case (idx)
      4'd2, 4'd4, 4'd11, 4'd13: return 1;
      4'd1, 4'd7, 4'd8, 4'd14: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [TAB_W-1:0] wrap_tab(int steps);
    int n;
    int r;
    n = cf_tabs;
    if (n == 0) n = 1;
    if (n > TAB_MAX) n = TAB_MAX;
    r = (int'(nav_tab) + steps) % n;
    if (r < 0) r += n;
    return r[TAB_W-1:0];
  endfunction

  function automatic logic [EV_W-1:0] poll_rule(logic btn, logic inh, logic [TIME_W-1:0] now);
    logic [EV_W-1:0]   ev;
    logic [TIME_W-1:0] hold;
    int                steps;
    ev = EV_NONE;
    if (nav_wake_pend && nav_asleep) begin
      nav_wake_pend = 1'b0;
      nav_asleep    = 1'b0;
      nav_last_act  = now;
      ev            = EV_WOKE;
    end
    if (nav_asleep) begin
      if (!cf_ext) begin
        if (btn) begin
          if (!nav_btn_held) begin
            nav_btn_held = 1'b1;
            nav_press_t  = now;
          end
        end else if (nav_btn_held && (now - nav_press_t) >= cf_min) begin
          nav_btn_held = 1'b0;
          nav_asleep   = 1'b0;
          nav_last_act = now;
          return EV_WOKE;
        end else begin
          nav_btn_held = 1'b0;
        end
      end
      return ev;
    end
    // Awake: pending encoder motion takes priority over the button.
    if (!inh && !cf_ext && nav_acc != 0) begin
      if (nav_acc >= DETENT) steps = nav_acc / DETENT;
      else if (nav_acc <= -DETENT) steps = -((-nav_acc) / DETENT);
      else steps = (nav_acc > 0) ? 1 : -1;
      nav_acc      = 0;
      nav_tab      = wrap_tab(steps);
      nav_last_act = now;
      return EV_MOVE;
    end
    if (!cf_ext) begin
      if (btn) begin
        if (!nav_btn_held) begin
          nav_btn_held = 1'b1;
          nav_press_t  = now;
        end
      end else if (nav_btn_held) begin
        hold         = now - nav_press_t;
        nav_last_act = now;
        nav_btn_held = 1'b0;
        if (hold >= cf_long) return EV_LONG;
        if (hold >= cf_min) begin
          nav_tab = wrap_tab(1);
          return EV_SHORT;
        end
        return ev;
      end
    end
    if ((now - nav_last_act) > cf_sleep) begin
      nav_asleep = 1'b1;
      return EV_SLEPT;
    end
    return ev;
  endfunction

  function automatic out_item_t tab_predict(in_item_t it);
    out_item_t  res;
    logic [1:0] cur;
    int         acc;
    logic [EV_W-1:0] ev;
    cur = {it.enc_a, it.enc_b};
    acc = nav_acc + enc_delta({nav_enc_prev, cur});
    nav_enc_prev = cur;
    if (acc > ACC_LIMIT) acc = ACC_LIMIT;
    if (acc < -ACC_LIMIT) acc = -ACC_LIMIT;
    nav_acc = acc;
    if (it.wake_request) nav_wake_pend = 1'b1;
    ev = EV_NONE;
    if (it.poll) ev = poll_rule(it.button_down, it.nav_inhibit, nav_now);
    nav_now = nav_now + TIME_W'(1);
    res.current_tab = nav_tab;
    res.sleeping    = nav_asleep;
    res.event_code  = ev;
    return res;
  endfunction

  // Sender: one transfer per accepted tick, with random gaps between ticks.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        exp_res.push_back(tab_predict(in_item_t'(in_tdata[IN_BITS-1:0])));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, tick_q.pop_front()};
          in_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 5);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer and stalls in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (exp_res.size() == 0) begin
          $display("%0t: result %h arrived with none expected", $time, out_tdata);
          mismatches++;
        end else begin
          mon_want = exp_res.pop_front();
          mon_got  = out_item_t'(out_tdata);
          if (mon_got.current_tab !== mon_want.current_tab) begin
            $display("%0t: current_tab expected %0d, got %0d", $time,
                     mon_want.current_tab, mon_got.current_tab);
            mismatches++;
          end
          if (mon_got.sleeping !== mon_want.sleeping) begin
            $display("%0t: sleeping expected %0d, got %0d", $time,
                     mon_want.sleeping, mon_got.sleeping);
            mismatches++;
          end
          if (mon_got.event_code !== mon_want.event_code) begin
            $display("%0t: event_code expected %0d, got %0d", $time,
                     mon_want.event_code, mon_got.event_code);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_tick(bit a, bit b, bit btn, bit poll, bit wake, bit inh);
    in_item_t it;
    it.enc_a        = a;
    it.enc_b        = b;
    it.button_down  = btn;
    it.poll         = poll;
    it.wake_request = wake;
    it.nav_inhibit  = inh;
    tick_q.push_back(it);
    queued_n++;
  endtask

  function automatic logic [1:0] gray_step(logic [1:0] lvl, bit up);
    case (lvl)
      2'b11: return up ? 2'b01 : 2'b10;
      2'b01: return up ? 2'b00 : 2'b11;
      2'b00: return up ? 2'b10 : 2'b01;
      default: return up ? 2'b11 : 2'b00;
    endcase
  endfunction

  // A clean quadrature rotation, closed by a poll tick.
  task automatic spin(bit up, int n, bit inh, bit rand_poll);
    repeat (n) begin
      enc_lvl = gray_step(enc_lvl, up);
      push_tick(enc_lvl[1], enc_lvl[0], 1'b0, rand_poll && $urandom_range(0, 7) == 0,
                1'b0, inh);
    end
    push_tick(enc_lvl[1], enc_lvl[0], 1'b0, 1'b1, 1'b0, inh);
  endtask

  // Button held for a number of ticks, then released on a poll tick.
  task automatic press(int hold, bit rand_poll);
    repeat (hold) begin
      push_tick(enc_lvl[1], enc_lvl[0], 1'b1,
                rand_poll ? ($urandom_range(0, 4) != 0) : 1'b1,
                rand_poll && $urandom_range(0, 15) == 0, 1'b0);
    end
    push_tick(enc_lvl[1], enc_lvl[0], 1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_tvalid || exp_res.size() != 0);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_TAB_COUNT:     cf_tabs  = data[TAB_CNT_W-1:0];
      REG_MIN_PRESS:     cf_min   = data[PRESS_W-1:0];
      REG_LONG_PRESS:    cf_long  = data[PRESS_W-1:0];
      REG_SLEEP_TIMEOUT: cf_sleep = data;
      REG_BUTTON_EXT:    cf_ext   = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] tabs, logic [31:0] minp, logic [31:0] longp,
                            logic [31:0] sleept, logic [31:0] ext);
    wait_idle();
    cfg_write(REG_TAB_COUNT, tabs);
    cfg_write(REG_MIN_PRESS, minp);
    cfg_write(REG_LONG_PRESS, longp);
    cfg_write(REG_SLEEP_TIMEOUT, sleept);
    cfg_write(REG_BUTTON_EXT, ext);
  endtask

  task automatic run_random(int n);
    int          stop;
    logic [31:0] r;
    stop = queued_n + n;
    while (queued_n < stop) begin
      r = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2: spin(r[0], $urandom_range(1, 12), $urandom_range(0, 4) == 0, 1'b1);
        3: begin
          // Occasionally a long inhibited spin drives the accumulator into saturation.
          if (r[1:0] == 2'd0) begin
            spin(r[2], $urandom_range(100, 160), 1'b1, 1'b0);
            push_tick(enc_lvl[1], enc_lvl[0], 1'b0, 1'b1, 1'b0, 1'b0);
          end else begin
            spin(r[2], $urandom_range(1, 6), 1'b0, 1'b0);
          end
        end
        4, 5: press($urandom_range(1, int'(cf_long) + 4), r[0]);
        6: push_tick(enc_lvl[1], enc_lvl[0], 1'b0, r[0], 1'b1, r[1]);
        7: repeat ($urandom_range(1, 25)) push_tick(enc_lvl[1], enc_lvl[0], 1'b0, 1'b1, 1'b0, 1'b0);
        default: begin
          push_tick(r[0], r[1], r[2], r[3], r[4], r[5]);
          enc_lvl = {r[0], r[1]};
        end
      endcase
    end
  endtask

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    nav_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: encoder moves, inhibited drain, wake request while awake.
    push_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    spin(1'b1, 4, 1'b0, 1'b0);
    spin(1'b0, 2, 1'b1, 1'b0);
    push_tick(enc_lvl[1], enc_lvl[0], 1'b0, 1'b1, 1'b0, 1'b0);
    push_tick(enc_lvl[1], enc_lvl[0], 1'b0, 1'b1, 1'b1, 1'b0);

    // Zero tabs, tiny thresholds: sleep, wake by the pending request, press cases.
    set_config(32'd0, 32'd0, 32'd3, 32'd2, 32'd0);
    repeat (6) push_tick(enc_lvl[1], enc_lvl[0], 1'b0, 1'b1, 1'b0, 1'b0);
    press(1, 1'b0);
    press(1, 1'b0);
    press(3, 1'b0);

    // Extremes, with navigation handled outside and noise in the upper data bits.
    set_config({27'h5A5A5A5, 5'd31}, 32'hFFFF_0000 | 32'd65535, 32'd65535,
               32'hFFFF_FFFF, 32'd1);
    cfg_write(REG_SPARE, $urandom);
    spin(1'b1, 2, 1'b0, 1'b0);
    press(2, 1'b0);
    wait_idle();
    cfg_write(REG_BUTTON_EXT, 32'd0);
    press(2, 1'b0);

    // Minimum above the long threshold.
    set_config(32'd16, 32'd5, 32'd2, 32'd1000, 32'd0);
    press(3, 1'b0);
    press(1, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      set_config(ph[0] ? 32'd16 :
                 (($urandom_range(0, 3) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 8)),
                 $urandom_range(0, 6), $urandom_range(0, 15), $urandom_range(0, 60),
                 ($urandom_range(0, 5) == 0));
      run_random(90);
      wait_idle();
      run_random(80);
    end

    wait_idle();
    idle_on = 1'b0;
    set_config($urandom_range(1, 16), $urandom_range(0, 4), $urandom_range(2, 12),
               $urandom_range(5, 40), 32'd0);
    run_random(100);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
